// ----- hdl/dhfk_pkg.sv -----
// Shared widths, constants, types and the arctangent table for the kinematics pipeline.
package dhfk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_W       = 5;
  localparam int JOINTS       = 6;
  localparam int JC_LAT       = 3;
  localparam int ANG_W        = 18;
  localparam int LEN_W        = 18;
  localparam int OUT_W        = 18;
  localparam int CFG_IDX_W    = 3;
  localparam int RED_W        = 36;
  localparam int CX_W         = 33;
  localparam int CS_W         = 32;
  localparam int ROT_W        = 32;
  localparam int POS_W        = 35;
  localparam int M_W          = 31;
  localparam int PRD_W        = 64;
  localparam int ACC_W        = 66;

  localparam logic signed [RED_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CX_W-1:0]  GAIN_Q30    = 33'sd652032874;
  localparam logic signed [ROT_W-1:0] ONE_Q28     = 32'sd268435456;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOREARM_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST_ONE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST_TWO_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOOL_OFFSET      = 3'd5;

  typedef enum logic [1:0] {
    TW_ZERO,
    TW_POS,
    TW_NEG
  } twist_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CX_W-1:0] z;
    logic                   neg;
  } cordic_t;

  typedef struct packed {
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
  } cs_t;

  typedef struct packed {
    logic [2:0][2:0][ROT_W-1:0] rot;
    logic [2:0][POS_W-1:0]      pos;
  } pose_t;

  function automatic logic signed [CX_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [CX_W-1:0] v;
    unique case (i)
      5'd0:    v = 33'sh03243F6A8;
      5'd1:    v = 33'sh01DAC6705;
      5'd2:    v = 33'sh00FADBAFC;
      5'd3:    v = 33'sh007F56EA6;
      5'd4:    v = 33'sh003FEAB76;
      5'd5:    v = 33'sh001FFD55B;
      5'd6:    v = 33'sh000FFFAAA;
      5'd7:    v = 33'sh0007FFF55;
      5'd8:    v = 33'sh0003FFFEA;
      5'd9:    v = 33'sh0001FFFFD;
      5'd10:   v = 33'sh0000FFFFF;
      5'd11:   v = 33'sh00007FFFF;
      5'd12:   v = 33'sh00003FFFF;
      5'd13:   v = 33'sh00001FFFF;
      5'd14:   v = 33'sh00000FFFF;
      5'd15:   v = 33'sh000007FFF;
      5'd16:   v = 33'sh000003FFF;
      5'd17:   v = 33'sh000001FFF;
      5'd18:   v = 33'sh000000FFF;
      5'd19:   v = 33'sh0000007FF;
      5'd20:   v = 33'sh0000003FF;
      5'd21:   v = 33'sh0000001FF;
      5'd22:   v = 33'sh0000000FF;
      5'd23:   v = 33'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/dhfk_cordic_cell.sv -----
// One rotation-mode CORDIC iteration with its output register.
module dhfk_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [dhfk_pkg::STEP_W-1:0] step,
  input  logic                        vld_in,
  input  dhfk_pkg::cordic_t           d_in,
  output logic                        vld_out,
  output dhfk_pkg::cordic_t           d_out
);
  import dhfk_pkg::*;

  logic                   vld_r;
  cordic_t                d_r;
  cordic_t                d_nxt;
  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;

  always_comb begin
    xs    = $signed(d_in.x) >>> step;
    ys    = $signed(d_in.y) >>> step;
    d_nxt = d_in;
    if (!d_in.z[CX_W-1]) begin
      d_nxt.x = $signed(d_in.x) - ys;
      d_nxt.y = $signed(d_in.y) + xs;
      d_nxt.z = $signed(d_in.z) - atan_q30(step);
    end else begin
      d_nxt.x = $signed(d_in.x) + ys;
      d_nxt.y = $signed(d_in.y) - xs;
      d_nxt.z = $signed(d_in.z) + atan_q30(step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

// ----- hdl/dhfk_sincos.sv -----
// Angle wrap and fold, CORDIC cell chain and Q28 rounding for one joint.
module dhfk_sincos (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_in,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle,
  output logic                              vld_out,
  output dhfk_pkg::cs_t                     cs_out
);
  import dhfk_pkg::*;

  function automatic logic signed [RED_W-1:0] wrap_pi(input logic signed [RED_W-1:0] z);
    logic signed [RED_W-1:0] r;
    r = z;
    if (z > PI_Q30) begin
      r = z - TWO_PI_Q30;
    end else if (z < -PI_Q30) begin
      r = z + TWO_PI_Q30;
    end
    return r;
  endfunction

  logic signed [RED_W-1:0] z0;
  logic signed [RED_W-1:0] z1_r;
  logic signed [RED_W-1:0] z2_r;
  logic signed [RED_W-1:0] zf;
  logic                    vld1_r;
  logic                    vld2_r;
  logic                    vld0_r;
  cordic_t                 fold_nxt;
  cordic_t                 chain [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0]   chain_vld;
  cordic_t                 fold_r;
  logic signed [CX_W-1:0]  xr;
  logic signed [CX_W-1:0]  yr;
  cs_t                     cs_nxt;
  cs_t                     cs_r;
  logic                    vld_r;

  assign z0 = RED_W'(angle) <<< 16;

  always_comb begin
    fold_nxt.x   = GAIN_Q30;
    fold_nxt.y   = '0;
    fold_nxt.neg = 1'b0;
    zf           = z2_r;
    if (z2_r > HALF_PI_Q30) begin
      zf           = z2_r - PI_Q30;
      fold_nxt.neg = 1'b1;
    end else if (z2_r < -HALF_PI_Q30) begin
      zf           = z2_r + PI_Q30;
      fold_nxt.neg = 1'b1;
    end
    fold_nxt.z = CX_W'(zf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld0_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld0_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r   <= wrap_pi(z0);
      z2_r   <= wrap_pi(z1_r);
      fold_r <= fold_nxt;
    end
  end

  assign chain[0]     = fold_r;
  assign chain_vld[0] = vld0_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    dhfk_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .step    (STEP_W'(g)),
      .vld_in  (chain_vld[g]),
      .d_in    (chain[g]),
      .vld_out (chain_vld[g+1]),
      .d_out   (chain[g+1])
    );
  end

  always_comb begin
    xr = ($signed(chain[CORDIC_STEPS].x) + CX_W'(signed'(2))) >>> 2;
    yr = ($signed(chain[CORDIC_STEPS].y) + CX_W'(signed'(2))) >>> 2;
    if (chain[CORDIC_STEPS].neg) begin
      cs_nxt.c = -CS_W'(xr);
      cs_nxt.s = -CS_W'(yr);
    end else begin
      cs_nxt.c = CS_W'(xr);
      cs_nxt.s = CS_W'(yr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= chain_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_nxt;
    end
  end

  assign vld_out = vld_r;
  assign cs_out  = cs_r;

endmodule

// ----- hdl/dhfk_joint_cell.sv -----
// One link of the transform chain: multiplies the running pose by one joint transform.
module dhfk_joint_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  dhfk_pkg::twist_t                  twist,
  input  logic signed [dhfk_pkg::LEN_W-1:0] link_a,
  input  logic signed [dhfk_pkg::LEN_W-1:0] link_d,
  input  dhfk_pkg::cs_t                     cs_in,
  input  logic                              vld_in,
  input  dhfk_pkg::pose_t                   pose_in,
  output logic                              vld_out,
  output dhfk_pkg::pose_t                   pose_out
);
  import dhfk_pkg::*;

  localparam int AC_W = LEN_W + CS_W;
  localparam logic signed [AC_W-1:0]  HALF16 = AC_W'(1) << 15;
  localparam logic signed [ACC_W-1:0] HALF28 = ACC_W'(1) << 27;

  function automatic logic signed [ACC_W-1:0] round28(input logic signed [ACC_W-1:0] v);
    return (v + HALF28) >>> 28;
  endfunction

  logic signed [AC_W-1:0]  prod_ac;
  logic signed [AC_W-1:0]  prod_as;
  logic                    s1_vld_r;
  pose_t                   s1_pose_r;
  logic signed [CS_W-1:0]  s1_c_r;
  logic signed [CS_W-1:0]  s1_s_r;
  logic signed [M_W-1:0]   s1_m03_r;
  logic signed [M_W-1:0]   s1_m13_r;
  logic signed [M_W-1:0]   s1_m23_r;

  logic                    s2_vld_r;
  pose_t                   s2_pose_r;
  logic signed [PRD_W-1:0] p0c_nxt [3];
  logic signed [PRD_W-1:0] p0s_nxt [3];
  logic signed [PRD_W-1:0] p1c_nxt [3];
  logic signed [PRD_W-1:0] p1s_nxt [3];
  logic signed [PRD_W-1:0] q0_nxt  [3];
  logic signed [PRD_W-1:0] q1_nxt  [3];
  logic signed [PRD_W-1:0] q2_nxt  [3];
  logic signed [PRD_W-1:0] p0c_r   [3];
  logic signed [PRD_W-1:0] p0s_r   [3];
  logic signed [PRD_W-1:0] p1c_r   [3];
  logic signed [PRD_W-1:0] p1s_r   [3];
  logic signed [PRD_W-1:0] q0_r    [3];
  logic signed [PRD_W-1:0] q1_r    [3];
  logic signed [PRD_W-1:0] q2_r    [3];

  logic                    s3_vld_r;
  pose_t                   s3_pose_r;
  pose_t                   s3_pose_nxt;

  assign prod_ac = link_a * cs_in.c;
  assign prod_as = link_a * cs_in.s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_in;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pose_r <= pose_in;
      s1_c_r    <= cs_in.c;
      s1_s_r    <= cs_in.s;
      s1_m03_r  <= M_W'((prod_ac + HALF16) >>> 16);
      s1_m13_r  <= M_W'((prod_as + HALF16) >>> 16);
      s1_m23_r  <= M_W'(link_d) <<< 12;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p0c_nxt[r] = $signed(s1_pose_r.rot[r][0]) * s1_c_r;
      p0s_nxt[r] = $signed(s1_pose_r.rot[r][0]) * s1_s_r;
      p1c_nxt[r] = $signed(s1_pose_r.rot[r][1]) * s1_c_r;
      p1s_nxt[r] = $signed(s1_pose_r.rot[r][1]) * s1_s_r;
      q0_nxt[r]  = $signed(s1_pose_r.rot[r][0]) * s1_m03_r;
      q1_nxt[r]  = $signed(s1_pose_r.rot[r][1]) * s1_m13_r;
      q2_nxt[r]  = $signed(s1_pose_r.rot[r][2]) * s1_m23_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pose_r <= s1_pose_r;
      p0c_r     <= p0c_nxt;
      p0s_r     <= p0s_nxt;
      p1c_r     <= p1c_nxt;
      p1s_r     <= p1s_nxt;
      q0_r      <= q0_nxt;
      q1_r      <= q1_nxt;
      q2_r      <= q2_nxt;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] col0;
    logic signed [ACC_W-1:0] col1;
    logic signed [ACC_W-1:0] col2;
    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] t2s;
    logic signed [ACC_W-1:0] qsum;
    s3_pose_nxt = s2_pose_r;
    for (int r = 0; r < 3; r++) begin
      col0 = ACC_W'(p0c_r[r]) + ACC_W'(p1s_r[r]);
      diff = ACC_W'(p1c_r[r]) - ACC_W'(p0s_r[r]);
      t2s  = ACC_W'($signed(s2_pose_r.rot[r][2])) <<< 28;
      qsum = ACC_W'(q0_r[r]) + ACC_W'(q1_r[r]) + ACC_W'(q2_r[r]);
      unique case (twist)
        TW_ZERO: begin
          col1 = diff;
          col2 = t2s;
        end
        TW_POS: begin
          col1 = t2s;
          col2 = -diff;
        end
        TW_NEG: begin
          col1 = -t2s;
          col2 = diff;
        end
        default: begin
          col1 = diff;
          col2 = t2s;
        end
      endcase
      s3_pose_nxt.rot[r][0] = ROT_W'(round28(col0));
      s3_pose_nxt.rot[r][1] = ROT_W'(round28(col1));
      s3_pose_nxt.rot[r][2] = ROT_W'(round28(col2));
      s3_pose_nxt.pos[r]    = POS_W'(round28(qsum)) + $signed(s2_pose_r.pos[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pose_r <= s3_pose_nxt;
    end
  end

  assign vld_out  = s3_vld_r;
  assign pose_out = s3_pose_r;

endmodule

// ----- hdl/six_joint_dh_forward_kinematics.sv -----
// Top level: six-joint DH forward kinematics pipeline with link configuration registers.
// Pipeline depth: 39 register stages (CORDIC_STEPS + 23).
// Throughput: one joint vector per cycle unless the output stalls; six CORDIC cell chains run
// side by side, then six joint cells of three stages each chain the transforms, then one
// rounding/saturation stage.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits and loads the default link lengths and offsets.
module six_joint_dh_forward_kinematics (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dhfk_pkg::ANG_W-1:0]     in_angle_one,
  input  logic signed [dhfk_pkg::ANG_W-1:0]     in_angle_two,
  input  logic signed [dhfk_pkg::ANG_W-1:0]     in_angle_three,
  input  logic signed [dhfk_pkg::ANG_W-1:0]     in_angle_four,
  input  logic signed [dhfk_pkg::ANG_W-1:0]     in_angle_five,
  input  logic signed [dhfk_pkg::ANG_W-1:0]     in_angle_six,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_xx,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_xy,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_xz,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_yx,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_yy,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_yz,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_zx,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_zy,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_rot_zz,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_pos_x,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_pos_y,
  output logic signed [dhfk_pkg::OUT_W-1:0]     out_pos_z,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dhfk_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic signed [dhfk_pkg::LEN_W-1:0]     cfg_data
);
  import dhfk_pkg::*;

  localparam logic signed [ROT_W-1:0] HALF12_R = 2048;
  localparam logic signed [POS_W-1:0] HALF12_P = 2048;
  localparam logic signed [ROT_W-1:0] ROT_MAX  = 65536;
  localparam logic signed [ROT_W-1:0] ROT_MIN  = -65536;
  localparam logic signed [POS_W-1:0] POS_MAX  = 131071;
  localparam logic signed [POS_W-1:0] POS_MIN  = -131072;

  logic                     en;
  logic signed [LEN_W-1:0]  base_height_r;
  logic signed [LEN_W-1:0]  upper_arm_length_r;
  logic signed [LEN_W-1:0]  forearm_length_r;
  logic signed [LEN_W-1:0]  wrist_one_offset_r;
  logic signed [LEN_W-1:0]  wrist_two_offset_r;
  logic signed [LEN_W-1:0]  tool_offset_r;

  logic signed [ANG_W-1:0]  angle   [JOINTS];
  twist_t                   twist   [JOINTS];
  logic signed [LEN_W-1:0]  link_a  [JOINTS];
  logic signed [LEN_W-1:0]  link_d  [JOINTS];
  logic [JOINTS-1:0]        sc_vld;
  cs_t                      sc_cs   [JOINTS];
  cs_t                      jc_cs   [JOINTS];
  pose_t                    pose    [0:JOINTS];
  logic [JOINTS:0]          pose_vld;

  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_rot_r   [3][3];
  logic signed [OUT_W-1:0]  out_rot_nxt [3][3];
  logic signed [OUT_W-1:0]  out_pos_r   [3];
  logic signed [OUT_W-1:0]  out_pos_nxt [3];

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r      <= 18'sd5843;
      upper_arm_length_r <= -18'sd27853;
      forearm_length_r   <= -18'sd25706;
      wrist_one_offset_r <= 18'sd7153;
      wrist_two_offset_r <= 18'sd6203;
      tool_offset_r      <= 18'sd5394;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_HEIGHT:      base_height_r      <= cfg_data;
        REG_UPPER_ARM_LENGTH: upper_arm_length_r <= cfg_data;
        REG_FOREARM_LENGTH:   forearm_length_r   <= cfg_data;
        REG_WRIST_ONE_OFFSET: wrist_one_offset_r <= cfg_data;
        REG_WRIST_TWO_OFFSET: wrist_two_offset_r <= cfg_data;
        REG_TOOL_OFFSET:      tool_offset_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    angle[0]  = in_angle_one;
    angle[1]  = in_angle_two;
    angle[2]  = in_angle_three;
    angle[3]  = in_angle_four;
    angle[4]  = in_angle_five;
    angle[5]  = in_angle_six;
    twist[0]  = TW_POS;
    twist[1]  = TW_ZERO;
    twist[2]  = TW_ZERO;
    twist[3]  = TW_POS;
    twist[4]  = TW_NEG;
    twist[5]  = TW_ZERO;
    link_a[0] = '0;
    link_a[1] = upper_arm_length_r;
    link_a[2] = forearm_length_r;
    link_a[3] = '0;
    link_a[4] = '0;
    link_a[5] = '0;
    link_d[0] = base_height_r;
    link_d[1] = '0;
    link_d[2] = '0;
    link_d[3] = wrist_one_offset_r;
    link_d[4] = wrist_two_offset_r;
    link_d[5] = tool_offset_r;
  end

  for (genvar j = 0; j < JOINTS; j++) begin : g_sc
    dhfk_sincos u_sincos (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (in_valid),
      .angle   (angle[j]),
      .vld_out (sc_vld[j]),
      .cs_out  (sc_cs[j])
    );
  end

  assign jc_cs[0] = sc_cs[0];

  for (genvar j = 1; j < JOINTS; j++) begin : g_dly
    cs_t dly_r [j*JC_LAT];
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= sc_cs[j];
        for (int k = 1; k < j * JC_LAT; k++) begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
    assign jc_cs[j] = dly_r[j*JC_LAT-1];
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        pose[0].rot[r][k] = (r == k) ? ONE_Q28 : '0;
      end
      pose[0].pos[r] = '0;
    end
  end
  assign pose_vld[0] = sc_vld[0];

  for (genvar j = 0; j < JOINTS; j++) begin : g_joint
    dhfk_joint_cell u_joint (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .twist    (twist[j]),
      .link_a   (link_a[j]),
      .link_d   (link_d[j]),
      .cs_in    (jc_cs[j]),
      .vld_in   (pose_vld[j]),
      .pose_in  (pose[j]),
      .vld_out  (pose_vld[j+1]),
      .pose_out (pose[j+1])
    );
  end

  always_comb begin
    logic signed [ROT_W-1:0] rr;
    logic signed [POS_W-1:0] pr;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        rr = ($signed(pose[JOINTS].rot[r][k]) + HALF12_R) >>> 12;
        if (rr > ROT_MAX) begin
          rr = ROT_MAX;
        end else if (rr < ROT_MIN) begin
          rr = ROT_MIN;
        end
        out_rot_nxt[r][k] = OUT_W'(rr);
      end
      pr = ($signed(pose[JOINTS].pos[r]) + HALF12_P) >>> 12;
      if (pr > POS_MAX) begin
        pr = POS_MAX;
      end else if (pr < POS_MIN) begin
        pr = POS_MIN;
      end
      out_pos_nxt[r] = OUT_W'(pr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pose_vld[JOINTS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot_r <= out_rot_nxt;
      out_pos_r <= out_pos_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rot_xx = out_rot_r[0][0];
  assign out_rot_xy = out_rot_r[0][1];
  assign out_rot_xz = out_rot_r[0][2];
  assign out_rot_yx = out_rot_r[1][0];
  assign out_rot_yy = out_rot_r[1][1];
  assign out_rot_yz = out_rot_r[1][2];
  assign out_rot_zx = out_rot_r[2][0];
  assign out_rot_zy = out_rot_r[2][1];
  assign out_rot_zz = out_rot_r[2][2];
  assign out_pos_x  = out_pos_r[0];
  assign out_pos_y  = out_pos_r[1];
  assign out_pos_z  = out_pos_r[2];

  a_sc_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    sc_vld == '0 || sc_vld == '1)
    else $error("sine/cosine chains out of step");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(pose_vld))
    else $error("pipeline moved during output stall");

  a_rot_xx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_rot_xx <= 18'sd65536 && out_rot_xx >= -18'sd65536)
    else $error("rot_xx beyond saturation range");

  a_rot_zz_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_rot_zz <= 18'sd65536 && out_rot_zz >= -18'sd65536)
    else $error("rot_zz beyond saturation range");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
